[hdl/rsa_pkg.sv]
// rsa_pkg: shared types and constants for the RGB saturation adjust pipeline.
// Holds the pixel and result word types, coefficient set and divider word.
// No dependencies.
package rsa_pkg;

  localparam int NUM_CH = 3;
  localparam int QUOT_W = 8;

  typedef logic        [7:0]  chan_t;
  typedef logic signed [9:0]  factor_t;
  typedef logic        [9:0]  sum_t;
  typedef logic        [9:0]  coef_u_t;
  typedef logic signed [9:0]  coef_s_t;
  typedef logic        [11:0] wide_t;
  typedef logic        [17:0] prod_t;
  typedef logic signed [18:0] qsum_t;
  typedef logic signed [19:0] num_t;
  typedef logic        [17:0] rem_t;

  localparam factor_t FACTOR_MAX = 10'sd256;
  localparam factor_t FACTOR_MIN = -10'sd256;
  localparam coef_u_t SCALE      = 10'd768;
  localparam chan_t   CHAN_MAX   = 8'd255;
  localparam chan_t   CHAN_MIN   = 8'd0;

  typedef struct packed {
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
  } pixel_t;

  typedef struct packed {
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
  } result_t;

  // out = (p*c + q*sum) / d, clamped to 0..255
  typedef struct packed {
    coef_u_t p;
    coef_s_t q;
    coef_u_t d;
  } coef_t;

  // channel index 2 = red, 1 = green, 0 = blue
  typedef struct packed {
    logic [NUM_CH-1:0][17:0]       rem;
    logic [NUM_CH-1:0][QUOT_W-1:0] quo;
    logic [NUM_CH-1:0]             zero;
    logic [NUM_CH-1:0]             sat;
    coef_u_t                       d;
  } div_word_t;

endpackage

[hdl/rsa_coef.sv]
// rsa_coef: turns the saturation factor into the coefficient set p, q, d.
// Depends on rsa_pkg.
module rsa_coef (
  input  rsa_pkg::factor_t factor,
  output rsa_pkg::coef_t   coef
);

  rsa_pkg::factor_t f;
  rsa_pkg::coef_u_t mag;
  rsa_pkg::wide_t   three_f;

  always_comb begin
    if (factor > rsa_pkg::FACTOR_MAX) begin
      f = rsa_pkg::FACTOR_MAX;
    end else if (factor < rsa_pkg::FACTOR_MIN) begin
      f = rsa_pkg::FACTOR_MIN;
    end else begin
      f = factor;
    end
  end

  always_comb begin
    if (f < 0) begin
      mag = rsa_pkg::coef_u_t'($unsigned(-f));
    end else begin
      mag = rsa_pkg::coef_u_t'($unsigned(f));
    end
    three_f = rsa_pkg::wide_t'(mag) * rsa_pkg::wide_t'(3);
  end

  // Blend toward the average: weight 768-3a on the channel, a on the sum.
  // Boost: 768 on the channel, -f on the sum, over 768-3f; threshold uses d = 1.
  always_comb begin
    if (f < 0) begin
      coef.p = rsa_pkg::coef_u_t'(rsa_pkg::wide_t'(rsa_pkg::SCALE) - three_f);
      coef.q = $signed(mag);
      coef.d = rsa_pkg::SCALE;
    end else begin
      coef.p = rsa_pkg::SCALE;
      coef.q = -f;
      if (f == rsa_pkg::FACTOR_MAX) begin
        coef.d = rsa_pkg::coef_u_t'(1);
      end else begin
        coef.d = rsa_pkg::coef_u_t'(rsa_pkg::wide_t'(rsa_pkg::SCALE) - three_f);
      end
    end
  end

endmodule

[hdl/rsa_front.sv]
// rsa_front: three pipeline stages that build each channel's numerator.
// Stage 1 sum, stage 2 products, stage 3 numerator and clamp flags. Uses rsa_pkg.
module rsa_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  rsa_pkg::pixel_t       pixel,
  input  rsa_pkg::coef_t        coef,
  output logic                  vld,
  output rsa_pkg::div_word_t    word
);

  logic                                      vld1;
  rsa_pkg::chan_t                            chan1 [rsa_pkg::NUM_CH];
  rsa_pkg::sum_t                             sum1;
  rsa_pkg::coef_t                            coef1;

  logic                                      vld2;
  rsa_pkg::prod_t                            pc2 [rsa_pkg::NUM_CH];
  rsa_pkg::qsum_t                            qs2;
  rsa_pkg::coef_u_t                          d2;

  rsa_pkg::num_t                             num [rsa_pkg::NUM_CH];
  rsa_pkg::num_t                             lim;
  rsa_pkg::div_word_t                        word_next;

  // Stage 1: capture pixel and coefficients, add the channels.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= accept;
    end
    chan1[2] <= pixel.red_in;
    chan1[1] <= pixel.green_in;
    chan1[0] <= pixel.blue_in;
    sum1     <= rsa_pkg::sum_t'(pixel.red_in) + rsa_pkg::sum_t'(pixel.green_in)
              + rsa_pkg::sum_t'(pixel.blue_in);
    coef1    <= coef;
  end

  // Stage 2: p*c per channel, q*sum shared.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
    for (int i = 0; i < rsa_pkg::NUM_CH; i++) begin
      pc2[i] <= rsa_pkg::prod_t'(coef1.p) * rsa_pkg::prod_t'(chan1[i]);
    end
    qs2 <= rsa_pkg::qsum_t'(coef1.q) * rsa_pkg::qsum_t'($signed({1'b0, sum1}));
    d2  <= coef1.d;
  end

  // Stage 3: numerator, flag results that clamp low or high.
  always_comb begin
    lim       = $signed({2'b00, d2, 8'h00});
    word_next = '0;
    word_next.d = d2;
    for (int i = 0; i < rsa_pkg::NUM_CH; i++) begin
      num[i] = rsa_pkg::num_t'($signed({1'b0, pc2[i]})) + rsa_pkg::num_t'(qs2);
      word_next.zero[i] = (num[i] <= 0);
      word_next.sat[i]  = (num[i] >= lim);
      word_next.rem[i]  = num[i][17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld2;
    end
    word <= word_next;
  end

endmodule

[hdl/rsa_div.sv]
// rsa_div: pipelined restoring divider, one quotient bit per stage, MSB first.
// Three channel lanes share the divisor carried in the word. Uses rsa_pkg.
module rsa_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               vld_in,
  input  rsa_pkg::div_word_t word_in,
  output logic               vld_out,
  output rsa_pkg::div_word_t word_out
);

  logic               vld_s  [rsa_pkg::QUOT_W+1];
  rsa_pkg::div_word_t word_s [rsa_pkg::QUOT_W+1];

  assign vld_s[0]  = vld_in;
  assign word_s[0] = word_in;

  for (genvar k = 0; k < rsa_pkg::QUOT_W; k++) begin : g_bit
    localparam int Sh = rsa_pkg::QUOT_W - 1 - k;

    rsa_pkg::rem_t      trial;
    rsa_pkg::div_word_t nxt;

    // Subtract the shifted divisor where it fits and set this quotient bit.
    always_comb begin
      trial = rsa_pkg::rem_t'(word_s[k].d) << Sh;
      nxt   = word_s[k];
      for (int i = 0; i < rsa_pkg::NUM_CH; i++) begin
        if (word_s[k].rem[i] >= trial) begin
          nxt.rem[i]     = word_s[k].rem[i] - trial;
          nxt.quo[i][Sh] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_s[k];
      end
      word_s[k+1] <= nxt;
    end
  end

  assign vld_out  = vld_s[rsa_pkg::QUOT_W];
  assign word_out = word_s[rsa_pkg::QUOT_W];

endmodule

[hdl/rgb_saturation_adjust.sv]
// rgb_saturation_adjust: per-pixel saturation boost, threshold or desaturate.
// Throughput one pixel word per cycle outside reset; an accepted word passes
// the numerator stages, divider and output register, then shows with done high.
// Depth is set by the eight-stage divider behind three numerator stages.
// Synchronous reset clears the factor to 0 (pass-through) and all valid bits;
// busy is high only during reset, and the receiver cannot stall.
module rgb_saturation_adjust (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rsa_pkg::pixel_t  pixel,
  output logic             done,
  output rsa_pkg::result_t result,
  input  logic             cfg_we,
  input  rsa_pkg::factor_t cfg_wdata
);

  rsa_pkg::factor_t   factor;
  rsa_pkg::coef_t     coef;
  logic               accept;
  logic               front_vld;
  rsa_pkg::div_word_t front_word;
  logic               div_vld;
  rsa_pkg::div_word_t div_word;
  rsa_pkg::chan_t     chan [rsa_pkg::NUM_CH];
  rsa_pkg::result_t   result_next;

  // The pipeline never backs up, so only reset holds off new words.
  assign busy   = rst;
  assign accept = start && !busy;

  // Factor register; write only while the pipeline is empty (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= '0;
    end else if (cfg_we) begin
      factor <= cfg_wdata;
    end
  end

  // Clamp the factor and derive the per-mode weights and divisor.
  rsa_coef u_coef (
    .factor (factor),
    .coef   (coef)
  );

  // Stages 1..3: sum, products, numerator with clamp flags.
  rsa_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .pixel  (pixel),
    .coef   (coef),
    .vld    (front_vld),
    .word   (front_word)
  );

  // Stages 4..11: one quotient bit per stage.
  rsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (front_vld),
    .word_in  (front_word),
    .vld_out  (div_vld),
    .word_out (div_word)
  );

  // Apply the clamps: a non-positive numerator gives 0, one at or above
  // 256 times the divisor gives 255, otherwise take the quotient.
  always_comb begin
    for (int i = 0; i < rsa_pkg::NUM_CH; i++) begin
      if (div_word.zero[i]) begin
        chan[i] = rsa_pkg::CHAN_MIN;
      end else if (div_word.sat[i]) begin
        chan[i] = rsa_pkg::CHAN_MAX;
      end else begin
        chan[i] = div_word.quo[i];
      end
    end
    result_next.red_out   = chan[2];
    result_next.green_out = chan[1];
    result_next.blue_out  = chan[0];
  end

  // Stage 12: output register, strobe for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_vld;
    end
    result <= result_next;
  end

  // Every accepted word comes out on result with done high.
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##12 done)
    else $error("accepted word did not emerge after 12 cycles");

  // No strobe without a matching accept.
  a_no_extra : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 12))
    else $error("result strobe without a matching accepted word");

  // The two clamp flags of a channel never fire together.
  a_flags : assert property (@(posedge clk) disable iff (rst)
    div_vld |-> ($onehot0({div_word.zero[0], div_word.sat[0]}) &&
                 $onehot0({div_word.zero[1], div_word.sat[1]}) &&
                 $onehot0({div_word.zero[2], div_word.sat[2]})))
    else $error("channel flagged both low and high clamp");

  // An unclamped channel 0 leaves the divider with a remainder below the divisor.
  a_rem : assert property (@(posedge clk) disable iff (rst)
    (div_vld && !div_word.zero[0] && !div_word.sat[0]) |->
      (div_word.rem[0] < rsa_pkg::rem_t'(div_word.d)))
    else $error("divider remainder not below divisor");

endmodule
